// ----- design/sie_pkg.sv -----
package sie_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_HI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_GIVEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_CR    = 3'd4;

    // characters of interest
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_PASS   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        LS_BEGIN  = 2'd0,
        LS_INLINE = 2'd1,
        LS_TEST   = 2'd2,
        LS_FOUND  = 2'd3
    } t_line;

    typedef enum logic [1:0] {
        ST_BODY      = 2'd0,
        ST_ENDED     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] name_lo;
        logic [63:0] name_hi;
        logic [4:0]  name_len;
        logic        name_given;
        logic        drop_cr;
        logic        rearm;        // a write that restarts the search this cycle
        logic        rearm_given;  // name_given value the restart uses
    } t_cfg;

endpackage

// ----- design/sie_if.sv -----
interface sie_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_file;

    modport source (output valid, output text_byte, output end_of_file, input ready);
    modport sink   (input valid, input text_byte, input end_of_file, output ready);
endinterface

interface sie_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;

    modport source (output valid, output out_byte, output status, input ready);
    modport sink   (input valid, input out_byte, input status, output ready);
endinterface

interface sie_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/sie_cfg_regs.sv -----
module sie_cfg_regs
    import sie_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sie_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    logic [63:0] r_name_lo;
    logic [63:0] r_name_hi;
    logic [4:0]  r_name_len;
    logic        r_name_given;
    logic        r_drop_cr;
    logic        wr;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_lo    <= '0;
            r_name_hi    <= '0;
            r_name_len   <= '0;
            r_name_given <= 1'b0;
            r_drop_cr    <= 1'b1;
        end else if (wr) begin
            unique case (i_cfg.index)
                REG_NAME_LO:    r_name_lo    <= i_cfg.data;
                REG_NAME_HI:    r_name_hi    <= i_cfg.data;
                REG_NAME_LEN:   r_name_len   <= i_cfg.data[4:0];
                REG_NAME_GIVEN: r_name_given <= i_cfg.data[0];
                REG_DROP_CR:    r_drop_cr    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.name_lo     = r_name_lo;
        o_cfg.name_hi     = r_name_hi;
        o_cfg.name_len    = r_name_len;
        o_cfg.name_given  = r_name_given;
        o_cfg.drop_cr     = r_drop_cr;
        // name and name_given writes restart the search
        o_cfg.rearm       = wr && (i_cfg.index == REG_NAME_LO || i_cfg.index == REG_NAME_HI ||
                                   i_cfg.index == REG_NAME_LEN ||
                                   i_cfg.index == REG_NAME_GIVEN);
        o_cfg.rearm_given = (i_cfg.index == REG_NAME_GIVEN) ? i_cfg.data[0] : r_name_given;
    end

endmodule

// ----- design/sie_core.sv -----
module sie_core
    import sie_pkg::*;
#(
    parameter int MAX_NAME_BYTES = 16
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    sie_in_if.sink    i_in,
    sie_out_if.source o_out
);

    localparam int LEN_W = $clog2(MAX_NAME_BYTES + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    // scanner state
    t_phase           r_phase, n_phase;
    t_line            r_line, n_line;
    logic [LEN_W-1:0] r_match, n_match;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_status    r_out_status;

    logic             fire;
    logic             emit;
    logic [7:0]       e_byte;
    t_status          e_status;
    logic [LEN_W-1:0] eff_len;
    logic [7:0]       name_sel;
    logic [127:0]     name_flat;

    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    assign name_flat = {i_cfg.name_hi, i_cfg.name_lo};
    assign eff_len   = (i_cfg.name_len > 5'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES)
                                                            : i_cfg.name_len[LEN_W-1:0];

    always_comb begin
        name_sel = '0;
        for (int k = 0; k < MAX_NAME_BYTES; k++) begin
            if (r_match == LEN_W'(k)) begin
                name_sel = name_flat[8*k +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.text_byte;
            r_in_eof  <= i_in.end_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PASS;
            r_line  <= LS_BEGIN;
            r_match <= '0;
        end else begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_match <= n_match;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_line   = r_line;
        n_match  = r_match;
        emit     = 1'b0;
        e_byte   = '0;
        e_status = ST_BODY;
        if (i_cfg.rearm) begin
            n_phase = i_cfg.rearm_given ? PH_SEARCH : PH_PASS;
            n_line  = LS_BEGIN;
            n_match = '0;
        end else if (fire) begin
            if (r_in_eof) begin
                if (r_phase == PH_SEARCH || r_phase == PH_PASS) begin
                    emit     = 1'b1;
                    e_status = (r_phase == PH_SEARCH) ? ST_NOT_FOUND : ST_ENDED;
                end
                n_phase = i_cfg.name_given ? PH_SEARCH : PH_PASS;
                n_line  = LS_BEGIN;
                n_match = '0;
            end else begin
                unique case (r_phase)
                    PH_SEARCH: begin
                        unique case (r_line)
                            LS_BEGIN: begin
                                if (r_in_byte == CH_OPEN) begin
                                    n_line  = LS_TEST;
                                    n_match = '0;
                                end else if (r_in_byte != CH_LF) begin
                                    n_line = LS_INLINE;
                                end
                            end
                            LS_INLINE: begin
                                if (r_in_byte == CH_LF) n_line = LS_BEGIN;
                            end
                            LS_TEST: begin
                                if (r_in_byte == CH_CLOSE) begin
                                    n_line = (r_match == eff_len) ? LS_FOUND : LS_INLINE;
                                end else if (r_match < eff_len && r_in_byte == name_sel) begin
                                    n_match = r_match + 1'b1;
                                end else begin
                                    n_line = LS_INLINE;
                                end
                            end
                            LS_FOUND: begin
                                // rest of the header line is skipped
                                if (r_in_byte == CH_LF) begin
                                    n_phase = PH_PASS;
                                    n_line  = LS_BEGIN;
                                    n_match = '0;
                                end
                            end
                        endcase
                    end
                    PH_PASS: begin
                        if (r_in_byte == CH_CR && i_cfg.drop_cr) begin
                            emit = 1'b0;
                        end else if (r_in_byte == CH_OPEN && r_line == LS_BEGIN) begin
                            n_phase  = PH_DONE;
                            emit     = 1'b1;
                            e_status = ST_ENDED;
                        end else begin
                            n_line = (r_in_byte == CH_LF) ? LS_BEGIN : LS_INLINE;
                            emit   = 1'b1;
                            e_byte = r_in_byte;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_byte   <= e_byte;
            r_out_status <= e_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.status   = r_out_status;

endmodule

// ----- design/ini_section_extractor.sv -----
// ini section extractor: streams a text file and forwards the body of one section
// i_in  : one word per file byte (text_byte, end_of_file); end_of_file closes the file
//         and re-arms the search, its byte is ignored
// o_out : one word per forwarded body byte (status 0), or a status word when the
//         section ends (1) or the named section was never found (2)
// i_cfg : register writes (index, data); always ready, take effect the next cycle;
//         writes to the name registers or to name_given restart the search
// throughput: one input word per cycle while o_out.ready stays high, since each byte
//   needs one state update and one name byte compare in the scan stage
// an accepted word passes the input register, then the result register, before
//   its result word is offered on o_out
// many input words give no result (header lines, dropped carriage returns, bytes
//   after the section ended)
// stall: a held result word keeps its value; the input register still takes one word,
//   then i_in.ready drops until o_out.ready returns
// reset: synchronous active low; pass mode with no name, drop_cr set, empty pipeline
module ini_section_extractor
    import sie_pkg::*;
#(
    parameter int MAX_NAME_BYTES = 16
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sie_in_if.sink    i_in,
    sie_out_if.source o_out,
    sie_cfg_if.sink   i_cfg
);

    // register file and restart strobe
    t_cfg cfg;

    sie_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register, scan state and result register
    sie_core #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ----- design/sie_checker.sv -----
module sie_checker
    import sie_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_status
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_out_status))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_BODY || i_out_status == ST_ENDED ||
                         i_out_status == ST_NOT_FOUND))
        else $error("unused status code");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_BODY |-> i_out_byte == 8'h00)
        else $error("status word carries a byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ini_section_extractor sie_checker u_sie_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_out_status (o_out.status)
);
